@@ rtl/gsef_pkg.sv @@
// shared constants, types and helpers for the greyscale sobel edge filter
package gsef_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 11;
    localparam int ROW_W         = 16;
    localparam int GRAD_W        = 11;
    localparam int SQ_W          = 20;
    localparam int SUM_W         = 21;
    localparam int ROOT_OP_W     = 16;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MIN_WIDTH     = 3;

    localparam logic [CFG_W-1:0]  WIDTH_RESET    = 11'd640;
    localparam logic [ROW_W-1:0]  ROW_MAX        = 16'hFFFF;
    localparam logic [SUM_W-1:0]  ROOT_SAT_LIMIT = 21'd65025;
    localparam logic [PIX_W-1:0]  ROOT_SAT_VALUE = 8'd255;

    // luma weights in 16-bit fixed point
    localparam logic [15:0] LUMA_B = 16'd7471;
    localparam logic [15:0] LUMA_G = 16'd38470;
    localparam logic [15:0] LUMA_R = 16'd19595;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] root;
    } root_rsp_t;

    function automatic logic [PIX_W-1:0] luma(input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] r);
        logic [23:0] acc;
        acc = 24'(b * LUMA_B) + 24'(g * LUMA_G) + 24'(r * LUMA_R);
        return acc[23:16];
    endfunction

endpackage

@@ rtl/gsef_line_mem.sv @@
// two-line grey store, one entry per column holding {row-2, row-1}
module gsef_line_mem #(
    parameter int DEPTH  = gsef_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [2*gsef_pkg::PIX_W-1:0] rd_data,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [2*gsef_pkg::PIX_W-1:0] wr_data
);
    import gsef_pkg::*;

    logic [2*PIX_W-1:0] mem [0:DEPTH-1];
    logic [2*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/gsef_root.sv @@
// iterative ceiling square root, one result bit per cycle, saturated to 255
module gsef_root (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gsef_pkg::SUM_W-1:0]  operand,
    output gsef_pkg::root_rsp_t         rsp
);
    import gsef_pkg::*;

    typedef enum logic [1:0] {R_IDLE, R_ITER, R_FIX, R_DONE} rstate_t;

    rstate_t              state_reg;
    logic [ROOT_OP_W-1:0] op_reg;
    logic [PIX_W-1:0]     root_reg;
    logic [2:0]           bit_reg;

    logic [PIX_W-1:0]     cand;
    logic [PIX_W-1:0]     mul_in;
    logic [ROOT_OP_W-1:0] mul_out;

    always_comb
    begin
        cand    = root_reg | (PIX_W'(1) << bit_reg);
        mul_in  = (state_reg == R_ITER) ? cand : root_reg;
        mul_out = mul_in * mul_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            op_reg    <= '0;
            root_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        if (operand > ROOT_SAT_LIMIT)
                        begin
                            root_reg  <= ROOT_SAT_VALUE;
                            state_reg <= R_DONE;
                        end
                        else
                        begin
                            op_reg    <= operand[ROOT_OP_W-1:0];
                            root_reg  <= '0;
                            bit_reg   <= 3'd7;
                            state_reg <= R_ITER;
                        end
                    end
                end
                R_ITER:
                begin
                    // keep the trial bit if its square still fits
                    if (mul_out <= op_reg)
                    begin
                        root_reg <= cand;
                    end
                    if (bit_reg == 3'd0)
                    begin
                        state_reg <= R_FIX;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 3'd1;
                    end
                end
                R_FIX:
                begin
                    // floor to ceiling when not a perfect square
                    if (mul_out != op_reg)
                    begin
                        root_reg <= root_reg + PIX_W'(1);
                    end
                    state_reg <= R_DONE;
                end
                R_DONE:
                begin
                    state_reg <= R_IDLE;
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = (state_reg == R_DONE);
    assign rsp.root = root_reg;

endmodule

@@ rtl/greyscale_sobel_edge_filter_top.sv @@
// top level of the greyscale sobel edge filter
//
// pixels arrive in raster order on the in channel (in_valid / in_ready) as
// blue, green, red and a frame_start flag that restarts row and column.
// each input transfer yields exactly one output transfer (out_valid /
// out_ready): the grey value of that pixel, plus the 3x3 sobel magnitude of
// the pixel one row up and one column left, flagged by edge_valid once that
// pixel has a full window (edge_value is 0 otherwise).
// image_width is written over the cfg channel (cfg_valid / cfg_ready), always
// ready; write it only while no pixel is in flight. values below 3 act as 3,
// above MAX_WIDTH as MAX_WIDTH.
// one pixel at a time: after the input transfer the block reads the line
// store and shifts the window, forms gradients and squares, and for an
// unsaturated interior pixel finds the root bit by bit and rounds it,
// then hands it off and loads the output register, so the bit-serial root
// sets the pace; the next pixel is taken the cycle after the load.
// results sit in an output register, so the next pixel is taken and worked
// on while the last result waits; a stalled receiver holds the block only at
// the final handoff. reset clears counters, window and width (to 640); the
// line store needs no clearing since rows 0 and 1 never flag an edge.
module greyscale_sobel_edge_filter_top #(
    parameter int MAX_WIDTH = gsef_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gsef_pkg::CFG_W-1:0]  image_width,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gsef_pkg::PIX_W-1:0]  blue,
    input  logic [gsef_pkg::PIX_W-1:0]  green,
    input  logic [gsef_pkg::PIX_W-1:0]  red,
    input  logic                        frame_start,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gsef_pkg::PIX_W-1:0]  grey_value,
    output logic                        edge_valid,
    output logic [gsef_pkg::PIX_W-1:0]  edge_value
);
    import gsef_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam logic [CNT_W-1:0] MAX_W_C = CNT_W'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] MIN_W_C = CNT_W'(MIN_WIDTH);

    typedef enum logic [2:0] {ST_IDLE, ST_MEM, ST_SUM, ST_ROOT, ST_DONE} state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   width_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   cur_col_reg;
    logic [PIX_W-1:0]   grey_reg;
    logic               interior_reg;
    logic [PIX_W-1:0]   win_reg [0:2][0:2];
    logic [PIX_W-1:0]   edge_reg;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_grey_reg;
    logic               out_evalid_reg;
    logic [PIX_W-1:0]   out_edge_reg;

    // position logic for the pixel being offered
    logic [CNT_W-1:0]   w_ext;
    logic [CNT_W-1:0]   act_w;
    logic [COL_W-1:0]   col_start;
    logic [ROW_W-1:0]   row_start;
    logic [COL_W-1:0]   col_cur;
    logic [ROW_W-1:0]   row_cur;
    logic [CNT_W-1:0]   col_plus;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_next;
    logic               interior_next;

    logic               in_xfer;
    logic               out_load;
    logic [2*PIX_W-1:0] mem_rd;

    logic signed [GRAD_W-1:0]   gx;
    logic signed [GRAD_W-1:0]   gy;
    logic signed [2*GRAD_W-1:0] gx_prod;
    logic signed [2*GRAD_W-1:0] gy_prod;
    logic [SUM_W-1:0]           mag_sq;
    root_rsp_t                  root_rsp;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        w_ext = CNT_W'(width_reg);
        if (w_ext < MIN_W_C)
        begin
            act_w = MIN_W_C;
        end
        else if (w_ext > MAX_W_C)
        begin
            act_w = MAX_W_C;
        end
        else
        begin
            act_w = w_ext;
        end

        col_start = frame_start ? '0 : col_reg;
        row_start = frame_start ? '0 : row_reg;

        // width shrank under a running row: wrap before taking the pixel
        if (CNT_W'(col_start) >= act_w)
        begin
            col_cur = '0;
            row_cur = (row_start == ROW_MAX) ? row_start : row_start + ROW_W'(1);
        end
        else
        begin
            col_cur = col_start;
            row_cur = row_start;
        end

        col_plus = CNT_W'(col_cur) + CNT_W'(1);
        if (col_plus >= act_w)
        begin
            col_next = '0;
            row_next = (row_cur == ROW_MAX) ? row_cur : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_plus[COL_W-1:0];
            row_next = row_cur;
        end

        interior_next = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
    end

    // sobel gradients, wrapping sums are exact since |g| <= 1020
    always_comb
    begin
        gx = GRAD_W'({3'b0, win_reg[0][2]}) + GRAD_W'({2'b0, win_reg[1][2], 1'b0})
           + GRAD_W'({3'b0, win_reg[2][2]})
           - GRAD_W'({3'b0, win_reg[0][0]}) - GRAD_W'({2'b0, win_reg[1][0], 1'b0})
           - GRAD_W'({3'b0, win_reg[2][0]});
        gy = GRAD_W'({3'b0, win_reg[2][0]}) + GRAD_W'({2'b0, win_reg[2][1], 1'b0})
           + GRAD_W'({3'b0, win_reg[2][2]})
           - GRAD_W'({3'b0, win_reg[0][0]}) - GRAD_W'({2'b0, win_reg[0][1], 1'b0})
           - GRAD_W'({3'b0, win_reg[0][2]});
        gx_prod = gx * gx;
        gy_prod = gy * gy;
        mag_sq  = SUM_W'(gx_prod[SQ_W-1:0]) + SUM_W'(gy_prod[SQ_W-1:0]);
    end

    gsef_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (col_cur),
        .rd_data (mem_rd),
        .wr_en   (state_reg == ST_MEM),
        .wr_addr (cur_col_reg),
        .wr_data ({mem_rd[PIX_W-1:0], grey_reg})
    );

    gsef_root u_root (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   ((state_reg == ST_SUM) && interior_reg),
        .operand (mag_sq),
        .rsp     (root_rsp)
    );

    // width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            width_reg <= image_width;
        end
    end

    // sequencer, counters, window and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            cur_col_reg    <= '0;
            grey_reg       <= '0;
            interior_reg   <= 1'b0;
            edge_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_grey_reg   <= '0;
            out_evalid_reg <= 1'b0;
            out_edge_reg   <= '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        grey_reg     <= luma(blue, green, red);
                        cur_col_reg  <= col_cur;
                        interior_reg <= interior_next;
                        col_reg      <= col_next;
                        row_reg      <= row_next;
                        state_reg    <= ST_MEM;
                    end
                end
                ST_MEM:
                begin
                    // line store data is here: shift the window left
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= mem_rd[2*PIX_W-1:PIX_W];
                    win_reg[1][2] <= mem_rd[PIX_W-1:0];
                    win_reg[2][2] <= grey_reg;
                    state_reg     <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (interior_reg)
                    begin
                        state_reg <= ST_ROOT;
                    end
                    else
                    begin
                        edge_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_ROOT:
                begin
                    if (root_rsp.done)
                    begin
                        edge_reg  <= root_rsp.root;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_grey_reg   <= grey_reg;
                        out_evalid_reg <= interior_reg;
                        out_edge_reg   <= edge_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign grey_value = out_grey_reg;
    assign edge_valid = out_evalid_reg;
    assign edge_value = out_edge_reg;

endmodule

@@ rtl/gsef_checker.sv @@
// port-level checks for the greyscale sobel edge filter, bound to the top level
module gsef_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [gsef_pkg::PIX_W-1:0]  grey_value,
    input logic                        edge_valid,
    input logic [gsef_pkg::PIX_W-1:0]  edge_value
);
    import gsef_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(grey_value)
            && $stable(edge_valid) && $stable(edge_value))
        else $error("output payload changed under stall");

    // border pixels carry a zero magnitude
    a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !edge_valid |-> edge_value == '0)
        else $error("edge value nonzero without edge flag");

    // one pixel at a time: busy for the window and gradient stages after a transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##1 !in_ready ##1 !in_ready)
        else $error("input taken while previous pixel in flight");

endmodule

bind greyscale_sobel_edge_filter_top gsef_checker u_gsef_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .grey_value (grey_value),
    .edge_valid (edge_valid),
    .edge_value (edge_value)
);

@@ dv/greyscale_sobel_edge_filter_checker.sv @@
// scoreboard for the greyscale sobel edge filter: predicts each output transfer and compares it
`timescale 1ns / 1ps
module greyscale_sobel_edge_filter_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [gsef_pkg::CFG_W-1:0] image_width,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [gsef_pkg::PIX_W-1:0] blue,
    input  logic [gsef_pkg::PIX_W-1:0] green,
    input  logic [gsef_pkg::PIX_W-1:0] red,
    input  logic                       frame_start,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [gsef_pkg::PIX_W-1:0] grey_value,
    input  logic                       edge_valid,
    input  logic [gsef_pkg::PIX_W-1:0] edge_value,
    output int                         pending_count,
    output int                         mismatch_count
);
    import gsef_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] grey;
        logic             flag;
        logic [PIX_W-1:0] magnitude;
    } pixel_result_t;

    pixel_result_t    expected_pixels[$];
    pixel_result_t    want;
    pixel_result_t    got;
    int               out_seen;

    logic [CFG_W-1:0] width_reg;
    logic [PIX_W-1:0] older_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] newer_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      col_pos;
    int unsigned      row_pos;

    function automatic void reset_model();
        width_reg = WIDTH_RESET;
        for (int i = 0; i < MAX_WIDTH_DEF; i++)
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        col_pos = 0;
        row_pos = 0;
        expected_pixels.delete();
        pending_count = 0;
    endfunction

    // smallest n with n*n >= sq, clipped at full scale
    function automatic logic [PIX_W-1:0] magnitude_root(input int unsigned sq);
        int unsigned n;
        if (sq > ROOT_SAT_LIMIT)
            return ROOT_SAT_VALUE;
        n = 0;
        while (n * n < sq)
            n++;
        return PIX_W'(n);
    endfunction

    function automatic pixel_result_t predict_pixel(input logic [PIX_W-1:0] b,
                                                    input logic [PIX_W-1:0] g,
                                                    input logic [PIX_W-1:0] r,
                                                    input logic             fs);
        int unsigned      span;
        int unsigned      col;
        int unsigned      luma_sum;
        int               gx;
        int               gy;
        int               wgt;
        logic [PIX_W-1:0] above2;
        logic [PIX_W-1:0] above1;
        pixel_result_t    res;
        span = width_reg;
        if (span < MIN_WIDTH)
            span = MIN_WIDTH;
        if (span > MAX_WIDTH_DEF)
            span = MAX_WIDTH_DEF;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        // a narrower width can leave the column past the row end
        if (col_pos >= span)
        begin
            col_pos = 0;
            if (row_pos < ROW_MAX)
                row_pos++;
        end
        col = col_pos;
        luma_sum = LUMA_B * b + LUMA_G * g + LUMA_R * r;
        res.grey = PIX_W'(luma_sum >> 16);

        above2 = older_line[col];
        above1 = newer_line[col];
        older_line[col] = above1;
        newer_line[col] = res.grey;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = above2;
        win[1][2] = above1;
        win[2][2] = res.grey;

        res.flag = 1'b0;
        res.magnitude = '0;
        if (row_pos >= 2 && col >= 2)
        begin
            gx = 0;
            gy = 0;
            for (int c = 0; c < 3; c++)
            begin
                wgt = (c == 1) ? 2 : 1;
                gx += wgt * (int'(win[c][2]) - int'(win[c][0]));
                gy += wgt * (int'(win[2][c]) - int'(win[0][c]));
            end
            res.flag = 1'b1;
            res.magnitude = magnitude_root(gx * gx + gy * gy);
        end

        col_pos = col + 1;
        if (col_pos >= span)
        begin
            col_pos = 0;
            if (row_pos < ROW_MAX)
                row_pos++;
        end
        return res;
    endfunction

    function automatic void note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, what);
    endfunction

    initial
    begin
        mismatch_count = 0;
        out_seen = 0;
        reset_model();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                width_reg = image_width;
            if (in_valid && in_ready)
                expected_pixels.push_back(predict_pixel(blue, green, red, frame_start));
            if (out_valid && out_ready)
            begin
                got = {grey_value, edge_valid, edge_value};
                if (expected_pixels.size() == 0)
                begin
                    note_failure($sformatf("output transfer %0d with no pixel outstanding",
                                           out_seen));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want)
                        note_failure($sformatf({"pixel %0d: expected grey %0d valid %0b",
                                                " magnitude %0d, got grey %0d valid %0b",
                                                " magnitude %0d"},
                                               out_seen, want.grey, want.flag,
                                               want.magnitude, got.grey, got.flag,
                                               got.magnitude));
                end
                out_seen++;
            end
            pending_count = expected_pixels.size();
        end
    end

endmodule

@@ dv/greyscale_sobel_edge_filter_top_tb.sv @@
// testbench top for the greyscale sobel edge filter: stimulus, stalls, watchdog and verdict
`timescale 1ns / 1ps
module greyscale_sobel_edge_filter_top_tb;
    import gsef_pkg::*;

    // cycles without any transfer before the run is declared hung; the slowest
    // legal pixel is the longest sender gap, the work on an interior pixel and
    // the longest receiver stall, so this is many times over
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PIXELS = 540;
    localparam int END_PAUSE     = 40;

    // content style of one random image
    typedef enum logic [1:0] {
        TEXTURE_NOISE,
        TEXTURE_SMOOTH,
        TEXTURE_HARD,
        TEXTURE_FLAT
    } texture_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] width_word  = WIDTH_RESET;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    logic [PIX_W-1:0] blue        = '0;
    logic [PIX_W-1:0] green       = '0;
    logic [PIX_W-1:0] red         = '0;
    logic             frame_start = 1'b0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    logic [PIX_W-1:0] grey_value;
    logic             edge_valid;
    logic [PIX_W-1:0] edge_value;

    int               pending_count;
    int               mismatch_count;
    // when set, neither side inserts gaps
    bit               quiet_mode  = 1'b0;
    int               idle_cycles;

    greyscale_sobel_edge_filter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .image_width (width_word),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .grey_value  (grey_value),
        .edge_valid  (edge_valid),
        .edge_value  (edge_value)
    );

    greyscale_sobel_edge_filter_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .image_width    (width_word),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .grey_value     (grey_value),
        .edge_valid     (edge_valid),
        .edge_value     (edge_value),
        .pending_count  (pending_count),
        .mismatch_count (mismatch_count)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: before each output transfer hold ready low for a random
    // number of cycles; lowering and raising always land on different edges
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = quiet_mode ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    // watchdog: any transfer on any channel counts as progress
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // one pixel transfer; called and returns at a falling edge. valid is only
    // lowered when a gap is drawn, so back to back pixels keep it high
    task automatic push_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] r, input logic fs);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        blue        <= b;
        green       <= g;
        red         <= r;
        frame_start <= fs;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    // stop sending and wait until every predicted pixel has come back;
    // the extra edge keeps the lowering of valid apart from any later raise
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // width register write, only with the block idle
    task automatic write_width(input int w);
        drain();
        cfg_valid  <= 1'b1;
        width_word <= CFG_W'(w);
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void make_pixel(input texture_t tex, input int base,
                                       output logic [PIX_W-1:0] b,
                                       output logic [PIX_W-1:0] g,
                                       output logic [PIX_W-1:0] r);
        case (tex)
            TEXTURE_NOISE:
            begin
                b = PIX_W'($urandom);
                g = PIX_W'($urandom);
                r = PIX_W'($urandom);
            end
            // small local variation keeps the magnitude below saturation
            TEXTURE_SMOOTH:
            begin
                b = PIX_W'(base + $urandom_range(0, 24));
                g = PIX_W'(base + $urandom_range(0, 24));
                r = PIX_W'(base + $urandom_range(0, 24));
            end
            TEXTURE_HARD:
            begin
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default:
            begin
                b = PIX_W'(base);
                g = PIX_W'(base);
                r = PIX_W'(base);
            end
        endcase
    endfunction

    // a run of pixels; restart sets frame_start on the first one, noisy
    // scatters the odd frame_start through the rest
    task automatic send_pixels(input int count, input texture_t tex, input bit restart,
                               input bit noisy);
        int               base;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;
        logic             fs;
        base = $urandom_range(0, 231);
        for (int k = 0; k < count; k++)
        begin
            make_pixel(tex, base, b, g, r);
            if (k == 0)
                fs = restart;
            else
                fs = noisy && ($urandom_range(0, 149) == 0);
            push_pixel(b, g, r, fs);
        end
    endtask

    initial
    begin
        int       pick;
        int       span;
        int       cur_span;
        int       rows;
        int       total;
        int       random_sent;
        bit       fresh;
        bit       rewrite;
        texture_t tex;
        logic [PIX_W-1:0] shade;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset width: channel extremes and alternating bit patterns, row 0 only
        push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        push_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        push_pixel(8'h80, 8'h01, 8'hFE, 1'b0);

        // narrowest width, hand-built 3x5 image: a zero magnitude where the
        // columns cancel, a saturated one across a horizontal step, then a
        // gentle ramp for an in-range root
        write_width(MIN_WIDTH);
        for (int k = 0; k < 15; k++)
        begin
            if (k < 9)
                shade = (k % 3 == 1) ? 8'h00 : 8'hFF;
            else if (k < 12)
                shade = 8'h00;
            else
                shade = PIX_W'(100 + 10 * (k % 3));
            push_pixel(shade, shade, shade, k == 0);
        end

        // width narrowed while a row is open: first with the column already
        // past the new width (a new row starts), then with it still inside
        write_width(17);
        send_pixels(4 * 17 + 10, TEXTURE_SMOOTH, 1'b1, 1'b0);
        write_width(5);
        send_pixels(42, TEXTURE_NOISE, 1'b0, 1'b0);
        write_width(4);
        send_pixels(30, TEXTURE_SMOOTH, 1'b0, 1'b0);

        // random images: mostly small widths, some wider, some below range
        cur_span = 4;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            rewrite = ($urandom_range(0, 4) != 0);
            if (rewrite)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 13)
                    span = $urandom_range(3, 12);
                else if (pick < 16)
                    span = $urandom_range(13, 40);
                else
                    span = $urandom_range(0, 2);
                write_width(span);
                cur_span = (span < MIN_WIDTH) ? MIN_WIDTH : span;
            end
            // a wider row would read line entries this frame never wrote, so
            // every new width starts a fresh frame
            fresh = rewrite ? 1'b1 : 1'($urandom_range(0, 1));
            quiet_mode = ($urandom_range(0, 4) == 0);
            tex = texture_t'($urandom_range(0, 3));
            rows = $urandom_range(2, 6);
            total = cur_span * rows;
            // some images are cut short
            if ($urandom_range(0, 9) == 0)
                total = $urandom_range(1, total);
            send_pixels(total, tex, fresh, 1'b1);
            random_sent += total;
        end

        drain();
        // catch any stray transfer after the last expected one
        repeat (END_PAUSE) @(negedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
